// File: sv/b2b_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types, constants and tables of the BLAKE2b-512 hash engine.
// ----------------------------------------------------------------------------
package b2b_pkg;

    localparam int unsigned WordW   = 64;
    localparam int unsigned BlkWrds = 16;
    localparam int unsigned ChnWrds = 8;
    localparam logic [7:0]  BlkBytes = 8'd128;
    localparam logic [63:0] ParamW0 = 64'h0000_0000_0101_0040;

    // four working words handled by one half mix
    typedef struct packed {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
        logic [WordW-1:0] d;
    } t_quad;

    // initialisation vector
    function automatic logic [63:0] iv_word(input logic [2:0] k);
        unique case (k)
            3'd0:    return 64'h6a09e667f3bcc908;
            3'd1:    return 64'hbb67ae8584caa73b;
            3'd2:    return 64'h3c6ef372fe94f82b;
            3'd3:    return 64'ha54ff53a5f1d36f1;
            3'd4:    return 64'h510e527fade682d1;
            3'd5:    return 64'h9b05688c2b3e6c1f;
            3'd6:    return 64'h1f83d9abfb41bd6b;
            default: return 64'h5be0cd19137e2179;
        endcase
    endfunction

    // message schedule: word index for round rnd, slot idx
    function automatic logic [3:0] perm_idx(input logic [3:0] rnd, input logic [3:0] idx);
        logic [63:0] row;
        unique case (rnd)
            4'd0, 4'd10: row = 64'hFEDCBA9876543210;
            4'd1, 4'd11: row = 64'h357B20C16DF984AE;
            4'd2:        row = 64'h491763EADF250C8B;
            4'd3:        row = 64'h8F04A562EBCD1397;
            4'd4:        row = 64'hD386CB1EFA427509;
            4'd5:        row = 64'h91EF57D438B0A6C2;
            4'd6:        row = 64'hB8293670A4DEF15C;
            4'd7:        row = 64'hA2684F05931CE7BD;
            4'd8:        row = 64'h5A417D2C803B9EF6;
            4'd9:        row = 64'h0DC3E9BF5167482A;
            default:     row = 64'hFEDCBA9876543210;
        endcase
        return row[{idx, 2'b00} +: 4];
    endfunction

    // working-vector indices a,b,c,d of mix g, packed {a,b,c,d}
    function automatic logic [15:0] mix_idx(input logic [2:0] g);
        unique case (g)
            3'd0:    return 16'h048C;
            3'd1:    return 16'h159D;
            3'd2:    return 16'h26AE;
            3'd3:    return 16'h37BF;
            3'd4:    return 16'h05AF;
            3'd5:    return 16'h16BC;
            3'd6:    return 16'h278D;
            default: return 16'h349E;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: sv/blake2b_hash_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A word that fills no block passes S_PRE, S_ABS and S_POST before the input frees again;
// a block compression loads the working vector (S_LOAD), runs the half mixes through the
// one half-G unit (S_RND) and writes the chain value back (S_FRD, S_FWR). Input is taken
// only in S_IDLE, so no new word is taken while a compression runs. A last word adds
// padding, the final compression, 8 digest items held until taken and a chain memory reload.
// Reset (synchronous, active low) starts that reload; no item is accepted during it.
// ----------------------------------------------------------------------------
// blake2b_hash_engine_unit
// Unkeyed BLAKE2b-512: block buffer and chain value in RAMs, one half-G unit.
// ----------------------------------------------------------------------------
module blake2b_hash_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // msg_word[63:0], byte_count[67:64], zero
    input  wire logic        s_axis_tlast,  // last_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,  // digest_word[63:0]
    output logic      [2:0]  m_axis_tuser,  // word_index[2:0]
    output logic             m_axis_tlast   // digest_last
);
    import b2b_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PRE, S_ABS, S_POST, S_PAD,
        S_LOAD, S_RND, S_FRD, S_FWR, S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [4:0]    r_k, n_k;
    logic [3:0]    r_rnd, n_rnd, r_idx, n_idx;
    logic [7:0]    r_fill, n_fill;
    logic [127:0]  r_cnt, n_cnt;
    logic [63:0]   r_acc, n_acc;
    logic          r_final, n_final, r_ret_abs, n_ret_abs;
    logic [63:0]   r_word, n_word;
    logic [3:0]    r_n, n_n;
    logic          r_last, n_last;
    logic [63:0]   r_v [16];
    logic [63:0]   n_v [16];
    logic [63:0]   r_odat, n_odat;
    logic [2:0]    r_oidx, n_oidx;

    logic          w_bwe, w_cwe;
    logic [3:0]    w_bwa, w_bra;
    logic [63:0]   w_bwd, w_brd, w_cwd, w_crd;
    logic [2:0]    w_cwa, w_cra;
    logic [15:0]   w_mix;
    t_quad         w_qi, w_qo;
    logic [63:0]   w_wm, w_h;
    logic [127:0]  w_comb;
    logic [3:0]    w_t;

    b2b_ram #(.WIDTH(WordW), .DEPTH(BlkWrds)) u_buf (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_bwa), .i_wdata(w_bwd),
        .i_raddr(w_bra), .o_rdata(w_brd)
    );

    b2b_ram #(.WIDTH(WordW), .DEPTH(ChnWrds)) u_chain (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(w_cwa), .i_wdata(w_cwd),
        .i_raddr(w_cra), .o_rdata(w_crd)
    );

    b2b_mix u_mix (.i_q(w_qi), .i_msg(w_brd), .i_half(r_idx[0]), .o_q(w_qo));

    // operands of the current half mix
    always_comb begin
        w_mix = mix_idx(r_idx[3:1]);
        w_qi  = '{a: r_v[w_mix[15:12]], b: r_v[w_mix[11:8]],
                  c: r_v[w_mix[7:4]],  d: r_v[w_mix[3:0]]};
    end

    // new bytes merged behind the partial word
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_wm[j*8 +: 8] = (4'(j) < r_n) ? r_word[j*8 +: 8] : 8'h00;
        end
        w_comb = {64'h0, r_acc} | ({64'h0, w_wm} << {r_fill[2:0], 3'b000});
        w_t    = {1'b0, r_fill[2:0]} + r_n;
        w_h    = w_crd ^ r_v[{1'b0, r_k[2:0]}] ^ r_v[{1'b1, r_k[2:0]}];
    end

    // control and datapath next state
    always_comb begin
        n_state = r_state;  n_k = r_k;  n_rnd = r_rnd;  n_idx = r_idx;
        n_fill = r_fill;    n_cnt = r_cnt;  n_acc = r_acc;  n_final = r_final;
        n_ret_abs = r_ret_abs;  n_word = r_word;  n_n = r_n;  n_last = r_last;
        n_v = r_v;  n_odat = r_odat;  n_oidx = r_oidx;
        w_bwe = 1'b0;  w_bwa = r_fill[6:3];  w_bwd = w_comb[63:0];
        w_cwe = 1'b0;  w_cwa = r_k[2:0];  w_cwd = w_h;  w_cra = r_k[2:0];
        unique case (r_state)
            S_INIT: begin
                w_cwe = 1'b1;
                w_cwd = iv_word(r_k[2:0]) ^ ((r_k[2:0] == 3'd0) ? ParamW0 : 64'h0);
                n_k = r_k + 5'd1;
                if (r_k[2:0] == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_word  = s_axis_tdata[63:0];
                    n_n     = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
                    n_last  = s_axis_tlast;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_fill == BlkBytes && r_n != 4'd0) begin
                    n_cnt = r_cnt + 128'(BlkBytes);
                    n_final = 1'b0;  n_ret_abs = 1'b1;
                    n_k = '0;  n_rnd = '0;  n_idx = '0;  n_state = S_LOAD;
                end else begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                if (w_t >= 4'd8) begin
                    w_bwe = 1'b1;
                    n_acc = w_comb[127:64];
                end else begin
                    n_acc = w_comb[63:0];
                end
                n_fill  = r_fill + {4'h0, r_n};
                n_state = S_POST;
            end
            S_POST: begin
                priority if (r_fill > BlkBytes) begin
                    n_cnt = r_cnt + 128'(BlkBytes);
                    n_final = 1'b0;  n_ret_abs = 1'b0;
                    n_k = '0;  n_rnd = '0;  n_idx = '0;  n_state = S_LOAD;
                end else if (r_last) begin
                    n_k = r_fill[7:3];
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (r_k[4]) begin
                    n_cnt = r_cnt + 128'(r_fill);
                    n_final = 1'b1;
                    n_k = '0;  n_rnd = '0;  n_idx = '0;  n_state = S_LOAD;
                end else begin
                    w_bwe = 1'b1;
                    w_bwa = r_k[3:0];
                    w_bwd = (r_k[3:0] == r_fill[6:3]) ? r_acc : 64'h0;
                    n_k = r_k + 5'd1;
                end
            end
            S_LOAD: begin
                if (r_k != 5'd0) begin
                    n_v[r_k[3:0] - 4'd1] = w_crd;
                end
                n_k = r_k + 5'd1;
                if (r_k == 5'd8) begin
                    for (int j = 0; j < 8; j++) begin
                        n_v[8+j] = iv_word(3'(j));
                    end
                    n_v[12] = iv_word(3'd4) ^ r_cnt[63:0];
                    n_v[13] = iv_word(3'd5) ^ r_cnt[127:64];
                    n_v[14] = iv_word(3'd6) ^ {64{r_final}};
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_v[w_mix[15:12]] = w_qo.a;
                n_v[w_mix[11:8]]  = w_qo.b;
                n_v[w_mix[7:4]]   = w_qo.c;
                n_v[w_mix[3:0]]   = w_qo.d;
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd15) begin
                    n_rnd = r_rnd + 4'd1;
                    if (r_rnd == 4'd11) begin
                        n_k = '0;
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                if (r_final) begin
                    n_odat = w_h;
                    n_oidx = r_k[2:0];
                    n_state = S_OUT;
                end else begin
                    w_cwe = 1'b1;
                    n_k = r_k + 5'd1;
                    n_state = S_FRD;
                    if (r_k[2:0] == 3'd7) begin
                        n_fill  = r_fill - BlkBytes;
                        n_state = r_ret_abs ? S_ABS : S_POST;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_k = r_k + 5'd1;
                    n_state = S_FRD;
                    if (r_k[2:0] == 3'd7) begin
                        n_k = '0;  n_fill = '0;  n_cnt = '0;  n_acc = '0;
                        n_state = S_INIT;
                    end
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // message word read in the cycle before its half mix
    assign w_bra = perm_idx(n_rnd, n_idx);

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_k     <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_final <= 1'b0;
            r_ret_abs <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_final <= n_final;
            r_ret_abs <= n_ret_abs;
        end
        r_word <= n_word;
        r_n    <= n_n;
        r_last <= n_last;
        r_v    <= n_v;
        r_odat <= n_odat;
        r_oidx <= n_oidx;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_odat;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);
endmodule
`default_nettype wire

// File: sv/b2b_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2b_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b2b_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/b2b_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2b_mix
// Half of the G function: one message word added, two add/xor/rotate pairs.
// ----------------------------------------------------------------------------
module b2b_mix (
    input  wire b2b_pkg::t_quad i_q,
    input  wire logic [63:0]    i_msg,
    input  wire logic           i_half,
    output b2b_pkg::t_quad      o_q
);
    import b2b_pkg::*;

    logic [63:0] w_a, w_dx, w_d, w_c, w_bx, w_b;

    // first half rotates by 32 and 24, second by 16 and 63
    always_comb begin
        w_a  = i_q.a + i_q.b + i_msg;
        w_dx = i_q.d ^ w_a;
        w_d  = i_half ? {w_dx[15:0], w_dx[63:16]} : {w_dx[31:0], w_dx[63:32]};
        w_c  = i_q.c + w_d;
        w_bx = i_q.b ^ w_c;
        w_b  = i_half ? {w_bx[62:0], w_bx[63]} : {w_bx[23:0], w_bx[63:24]};
        o_q  = '{a: w_a, b: w_b, c: w_c, d: w_d};
    end
endmodule
`default_nettype wire

// File: sv/b2b_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2b_checker
// Port-level checks of the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module b2b_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // nothing offered straight after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("digest item offered after reset");

    // a stalled digest item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled digest item changed");

    // last flag only on the eighth word
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("digest last flag mismatch");

    // no message item taken while the digest drains
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during digest output");
endmodule

bind blake2b_hash_engine_unit b2b_checker u_b2b_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
